@@ rtl/lmrs_pkg.sv @@
// Shared constants, types and helpers for the LED matrix row scan engine.
`timescale 1ns / 1ps

package lmrs_pkg;

	localparam int ROW_COUNT     = 8;
	localparam int BYTES_PER_ROW = 4;

	localparam int PLANE_DEPTH = 32;
	localparam int ADDR_W      = 5;
	localparam int ROW_W       = 3;
	localparam int COL_W       = 5;
	localparam int BLINK_W     = 16;
	localparam int MAX_COLUMNS = 32;

	// columns actually shifted per row, and the bytes they come from
	localparam int NCOLS   = (BYTES_PER_ROW * 8 > MAX_COLUMNS) ? MAX_COLUMNS : BYTES_PER_ROW * 8;
	localparam int NBYTES  = NCOLS / 8;
	localparam int BYTE_W  = (NBYTES > 1) ? $clog2(NBYTES) : 1;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_LIMIT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_THRESH = 1'b1;

	localparam logic [BLINK_W-1:0] BLINK_LIMIT_RST  = 16'd200;
	localparam logic [BLINK_W-1:0] BLINK_THRESH_RST = 16'd100;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SHIFT
	} scan_state_t;

	// one address of all four planes
	typedef struct packed {
		logic [7:0] blink_red;
		logic [7:0] blink_green;
		logic [7:0] red;
		logic [7:0] green;
	} plane_word_t;

	typedef struct packed {
		logic        func;
		logic [ADDR_W-1:0] addr;
		plane_word_t word;
	} in_item_t;

	typedef struct packed {
		logic        en;
		logic [ADDR_W-1:0] addr;
		plane_word_t data;
	} plane_wr_t;

	typedef struct packed {
		logic        en;
		logic [ADDR_W-1:0] addr;
	} plane_rd_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_select;
		logic [COL_W-1:0] column;
		logic             green_on;
		logic             red_on;
		logic             latch;
	} out_item_t;

	// plane index of byte b of a row, wrapping over the plane depth
	function automatic logic [ADDR_W-1:0] plane_addr(input logic [ROW_W-1:0] row, input int b);
		int sum;
		sum = int'(row) * BYTES_PER_ROW + b;
		return ADDR_W'(sum);
	endfunction

endpackage

@@ rtl/lmrs_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module lmrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lmrs_plane_store.sv @@
// Frame plane store: RAM holding all four planes plus per-entry valid bits.
`timescale 1ns / 1ps

module lmrs_plane_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lmrs_pkg::plane_wr_t  wr,
	input  lmrs_pkg::plane_rd_t  rd,
	output lmrs_pkg::plane_word_t rd_data
);

	logic [lmrs_pkg::PLANE_DEPTH-1:0] valid_q;
	logic                             valid_rd_q;
	logic [$bits(lmrs_pkg::plane_word_t)-1:0] ram_rdata;

	lmrs_ram #(
		.WIDTH($bits(lmrs_pkg::plane_word_t)),
		.DEPTH(lmrs_pkg::PLANE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (rd.en),
		.raddr(rd.addr),
		.rdata(ram_rdata)
	);

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				valid_rd_q <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = valid_rd_q ? lmrs_pkg::plane_word_t'(ram_rdata) : '0;

endmodule

@@ rtl/lmrs_scan.sv @@
// Row scan sequencer: counters, plane fetch, column shifter and output register.
`timescale 1ns / 1ps

module lmrs_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  lmrs_pkg::in_item_t                  in_item,
	input  logic [lmrs_pkg::BLINK_W-1:0]        blink_limit,
	input  logic [lmrs_pkg::BLINK_W-1:0]        blink_thresh,
	output lmrs_pkg::plane_wr_t                 wr,
	output lmrs_pkg::plane_rd_t                 rd,
	input  lmrs_pkg::plane_word_t               rd_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output lmrs_pkg::out_item_t                 m_item
);

	localparam logic [lmrs_pkg::BYTE_W-1:0] LAST_BYTE = lmrs_pkg::BYTE_W'(lmrs_pkg::NBYTES - 1);
	localparam logic [lmrs_pkg::COL_W-1:0]  LAST_COL  = lmrs_pkg::COL_W'(lmrs_pkg::NCOLS - 1);
	localparam logic [lmrs_pkg::ROW_W:0]    ROW_LIMIT = (lmrs_pkg::ROW_W + 1)'(lmrs_pkg::ROW_COUNT);

	lmrs_pkg::scan_state_t state_q, state_d;

	logic [lmrs_pkg::ROW_W-1:0]   row_q, row_d;
	logic [lmrs_pkg::BLINK_W-1:0] blink_q, blink_d;
	logic [lmrs_pkg::BYTE_W-1:0]  byte_q, byte_d, next_byte;
	logic [2:0]                   bit_q, bit_d;
	logic [7:0]                   bits_g_q, bits_g_d, bits_r_q, bits_r_d;
	logic                         m_tvalid_q, m_tvalid_d;
	lmrs_pkg::out_item_t          out_q, out_d;

	logic                         accept;
	logic                         out_free;
	logic                         emit;
	logic                         blink_on;
	logic [lmrs_pkg::ROW_W:0]     row_inc;
	logic [lmrs_pkg::COL_W-1:0]   col;
	logic [7:0]                   ld_g, ld_r;

	assign s_tready = (state_q == lmrs_pkg::S_IDLE);

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign blink_on  = blink_q > blink_thresh;
	assign row_inc   = {1'b0, row_q} + 1'b1;
	assign next_byte = byte_q + lmrs_pkg::BYTE_W'(1);
	assign col       = lmrs_pkg::COL_W'({byte_q, bit_q});
	assign ld_g      = rd_data.green | (blink_on ? rd_data.blink_green : 8'h00);
	assign ld_r      = rd_data.red | (blink_on ? rd_data.blink_red : 8'h00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lmrs_pkg::S_IDLE;
			row_q      <= '0;
			blink_q    <= '0;
			byte_q     <= '0;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			row_q      <= row_d;
			blink_q    <= blink_d;
			byte_q     <= byte_d;
			bit_q      <= bit_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		bits_g_q <= bits_g_d;
		bits_r_q <= bits_r_d;
		out_q    <= out_d;
	end

	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		blink_d    = blink_q;
		byte_d     = byte_q;
		bit_d      = bit_q;
		bits_g_d   = bits_g_q;
		bits_r_d   = bits_r_q;
		out_d      = out_q;
		emit       = 1'b0;
		wr.en      = 1'b0;
		wr.addr    = in_item.addr;
		wr.data    = in_item.word;
		rd.en      = 1'b0;
		rd.addr    = '0;

		unique case (state_q)
			lmrs_pkg::S_IDLE: begin
				if (accept) begin
					if (in_item.func == lmrs_pkg::FUNC_TICK) begin
						row_d   = (row_inc >= ROW_LIMIT) ? '0 : row_inc[lmrs_pkg::ROW_W-1:0];
						blink_d = (blink_q > blink_limit) ? '0 : blink_q + 1'b1;
						rd.en   = 1'b1;
						rd.addr = lmrs_pkg::plane_addr(row_d, 0);
						byte_d  = '0;
						state_d = lmrs_pkg::S_FETCH;
					end else begin
						wr.en = 1'b1;
					end
				end
			end
			lmrs_pkg::S_FETCH: begin
				bits_g_d = ld_g;
				bits_r_d = ld_r;
				bit_d    = '0;
				// prefetch the next byte; RAM output holds it until loaded
				if (byte_q != LAST_BYTE) begin
					rd.en   = 1'b1;
					rd.addr = lmrs_pkg::plane_addr(row_q, int'(byte_q) + 1);
				end
				state_d = lmrs_pkg::S_SHIFT;
			end
			lmrs_pkg::S_SHIFT: begin
				if (out_free) begin
					emit             = 1'b1;
					out_d.row_select = row_q;
					out_d.column     = col;
					out_d.green_on   = bits_g_q[7];
					out_d.red_on     = bits_r_q[7];
					out_d.latch      = (col == LAST_COL);
					if (bit_q == 3'd7) begin
						if (byte_q == LAST_BYTE) begin
							state_d = lmrs_pkg::S_IDLE;
						end else begin
							bits_g_d = ld_g;
							bits_r_d = ld_r;
							bit_d    = '0;
							byte_d   = next_byte;
							if (next_byte != LAST_BYTE) begin
								rd.en   = 1'b1;
								rd.addr = lmrs_pkg::plane_addr(row_q, int'(byte_q) + 2);
							end
						end
					end else begin
						bits_g_d = {bits_g_q[6:0], 1'b0};
						bits_r_d = {bits_r_q[6:0], 1'b0};
						bit_d    = bit_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = lmrs_pkg::S_IDLE;
			end
		endcase

		if (emit) begin
			m_tvalid_d = 1'b1;
		end else if (m_tready) begin
			m_tvalid_d = 1'b0;
		end else begin
			m_tvalid_d = m_tvalid_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_item   = out_q;

	a_latch_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		emit && out_d.latch |=> state_q == lmrs_pkg::S_IDLE)
		else $error("latch result did not end the row");

	a_midrow_stays: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !out_d.latch |=> state_q == lmrs_pkg::S_SHIFT)
		else $error("row ended before the latch column");

	a_fetch_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lmrs_pkg::S_FETCH |=> state_q == lmrs_pkg::S_SHIFT && bit_q == 3'd0)
		else $error("fetch did not start a fresh byte");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} < ROW_LIMIT)
		else $error("row counter out of range");

	a_out_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid)
		else $error("emitted item not presented");

endmodule

@@ rtl/led_matrix_row_scan.sv @@
// Top level of the bicolor LED matrix row scan engine.
`timescale 1ns / 1ps

// Four 32-byte planes (green, red, blink green, blink red) live in one
// 32-bit wide RAM; a write item stores one byte into each plane at the given
// address and gives no result. A tick item steps the row counter (first row
// after reset is 1) and the blink counter, then shifts the row out MSB first,
// one result per column, with tlast on the last column. A tick is accepted in
// the idle state, which issues the first plane read; the fetch state loads the
// RAM output; the shift state then sends one column per cycle, while the output
// does not stall, through the single output register, with each following byte
// prefetched while the current one shifts. No new item is accepted until the
// row is out. Planes read as zero until written after reset (per-entry valid
// bits, no clearing pass).
module led_matrix_row_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [4:0] address, [12:5] green_byte, [20:13] red_byte,
	// [28:21] blink_green_byte, [36:29] blink_red_byte, [39:37] zero
	input  logic [lmrs_pkg::S_TDATA_W-1:0]      s_tdata,
	// [0] func
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] row_select, [7:3] column, [8] green_on, [9] red_on, [15:10] zero
	output logic [lmrs_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lmrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lmrs_pkg::BLINK_W-1:0]        cfg_data
);

	logic [lmrs_pkg::BLINK_W-1:0] blink_limit_q;
	logic [lmrs_pkg::BLINK_W-1:0] blink_thresh_q;
	lmrs_pkg::in_item_t           in_item;
	lmrs_pkg::plane_wr_t          wr;
	lmrs_pkg::plane_rd_t          rd;
	lmrs_pkg::plane_word_t        rd_data;
	lmrs_pkg::out_item_t          m_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_limit_q  <= lmrs_pkg::BLINK_LIMIT_RST;
			blink_thresh_q <= lmrs_pkg::BLINK_THRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lmrs_pkg::CFG_BLINK_LIMIT:  blink_limit_q  <= cfg_data;
				lmrs_pkg::CFG_BLINK_THRESH: blink_thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_item.func              = s_tuser;
	assign in_item.addr              = s_tdata[4:0];
	assign in_item.word.green        = s_tdata[12:5];
	assign in_item.word.red          = s_tdata[20:13];
	assign in_item.word.blink_green  = s_tdata[28:21];
	assign in_item.word.blink_red    = s_tdata[36:29];

	lmrs_plane_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.rd_data(rd_data)
	);

	lmrs_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.in_item     (in_item),
		.blink_limit (blink_limit_q),
		.blink_thresh(blink_thresh_q),
		.wr          (wr),
		.rd          (rd),
		.rd_data     (rd_data),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_item      (m_item)
	);

	assign m_tdata = {6'b0, m_item.red_on, m_item.green_on, m_item.column, m_item.row_select};
	assign m_tlast = m_item.latch;

endmodule
